// ===== src/dfr_pkg.sv =====
// Shared types, constants and the CRC byte update for the DLE frame receiver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dfr_pkg;

  // Receive buffer size and the byte count at which the count restarts.
  localparam int unsigned BufferBytes = 256;
  localparam int unsigned CountLimit  = BufferBytes - 2;
  localparam int unsigned CntW        = $clog2(BufferBytes - 1);

  // Link control characters.
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChDle = 8'h10;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // Result event codes.
  localparam logic [2:0] EvNone   = 3'd0;
  localparam logic [2:0] EvStart  = 3'd1;
  localparam logic [2:0] EvStored = 3'd2;
  localparam logic [2:0] EvGood   = 3'd3;
  localparam logic [2:0] EvReject = 3'd4;

  // Queue between the classifier and the frame engine.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SOH,
    KIND_EOT,
    KIND_STORE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cls_word_t;

  // One byte into a CRC-16 with polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/dfr_front.sv =====
// Front end of the DLE frame receiver: takes raw bytes and classifies them.
// Tracks the DLE escape; depends on dfr_pkg.
`default_nettype none

module dfr_front import dfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output cls_word_t       push_word_o
);

  logic  escape_q, escape_d;
  kind_e kind;
  logic  accept;

  assign rx_ready_o   = push_ready_i;
  assign push_valid_o = rx_valid_i;
  assign accept       = rx_valid_i && push_ready_i;

  always_comb begin
    kind     = KIND_STORE;
    escape_d = escape_q;
    if (escape_q) begin
      kind     = KIND_STORE;
      escape_d = 1'b0;
    end else if (rx_byte_i == ChSoh) begin
      kind = KIND_SOH;
    end else if (rx_byte_i == ChEot) begin
      kind = KIND_EOT;
    end else if (rx_byte_i == ChDle) begin
      // A lone DLE only arms the escape; the word still goes through so
      // the count limit check happens in order.
      kind     = KIND_NONE;
      escape_d = 1'b1;
    end
  end

  assign push_word_o.kind = kind;
  assign push_word_o.data = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b0;
    end else if (accept) begin
      escape_q <= escape_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/dfr_queue.sv =====
// Short queue of classified words between front end and frame engine.
// Depends on dfr_pkg for the word type and depth.
`default_nettype none

module dfr_queue import dfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cls_word_t push_word_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cls_word_t pop_word_o
);

  cls_word_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     fill_q;
  logic                   do_push, do_pop;

  assign push_ready_o = fill_q != (QueuePtrW+1)'(QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dfr_back.sv =====
// Frame engine of the DLE frame receiver: byte count, lagging CRC, result register.
// Consumes classified words from dfr_queue; depends on dfr_pkg.
`default_nettype none

module dfr_back import dfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  cls_word_t       pop_word_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [2:0]      event_res_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      payload_length_o,
  output logic            wrapped_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      older_q, older_d, newer_q, newer_d;
  logic            res_valid_q;
  logic [2:0]      ev_q, ev_d;
  logic [7:0]      data_q, data_d, idx_q, idx_d, plen_q, plen_d;
  logic            wrap_q, wrap_d;
  logic            step;
  logic [31:0]     cnt_wide, plen_wide;

  // The result register frees up in the same cycle it is taken.
  assign pop_ready_o = !res_valid_q || res_ready_i;
  assign step        = pop_valid_i && pop_ready_o;

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    older_d = older_q;
    newer_d = newer_q;
    ev_d    = EvNone;
    data_d  = 8'h00;
    idx_d   = 8'h00;
    plen_d  = 8'h00;
    wrap_d  = 1'b0;

    if (count_q >= CntW'(CountLimit)) begin
      count_d = '0;
      crc_d   = '0;
      older_d = '0;
      newer_d = '0;
      wrap_d  = 1'b1;
    end

    cnt_wide  = 32'(count_d);
    plen_wide = cnt_wide - 32'd2;

    unique case (pop_word_i.kind)
      KIND_SOH: begin
        count_d = '0;
        crc_d   = '0;
        older_d = '0;
        newer_d = '0;
        ev_d    = EvStart;
      end
      KIND_EOT: begin
        // The last two stored bytes are the CRC, low byte first.
        if (count_d > CntW'(2) && {newer_d, older_d} == crc_d) begin
          ev_d   = EvGood;
          plen_d = plen_wide[7:0];
        end else begin
          ev_d = EvReject;
        end
      end
      KIND_STORE: begin
        if (count_d >= CntW'(2)) begin
          crc_d = crc_absorb(crc_d, older_d);
        end
        older_d = newer_d;
        newer_d = pop_word_i.data;
        ev_d    = EvStored;
        data_d  = pop_word_i.data;
        idx_d   = cnt_wide[7:0];
        count_d = count_d + 1'b1;
      end
      KIND_NONE: begin
        ev_d = EvNone;
      end
      default: begin
        ev_d = EvNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        count_q <= count_d;
        crc_q   <= crc_d;
        older_q <= older_d;
        newer_q <= newer_d;
      end
      if (pop_ready_o) begin
        res_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev_q   <= ev_d;
      data_q <= data_d;
      idx_q  <= idx_d;
      plen_q <= plen_d;
      wrap_q <= wrap_d;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign event_res_o      = ev_q;
  assign data_byte_o      = data_q;
  assign byte_index_o     = idx_q;
  assign payload_length_o = plen_q;
  assign wrapped_o        = wrap_q;

endmodule

`default_nettype wire

// ===== src/dle_frame_receiver_crc16.sv =====
// DLE-escaped frame receiver with CRC-16 (poly 0x1021, init 0, MSB first).
// Every received byte is taken as one word and yields exactly one result word,
// at a sustained rate of one byte per clock while res_ready_i does not stall the
// output. Each byte passes the classifier, a two-entry queue, then the frame
// engine and its result register. SOH starts a frame, EOT ends it and DLE
// makes the next byte plain data. The CRC trails the stored bytes by two, so
// at EOT the last two bytes are checked as the frame CRC, low byte first.
// Depends on dfr_pkg, dfr_front, dfr_queue and dfr_back.
`default_nettype none

module dle_frame_receiver_crc16 import dfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [2:0]      event_res_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      payload_length_o,
  output logic            wrapped_o
);

  logic      push_valid, push_ready;
  cls_word_t push_word;
  logic      pop_valid, pop_ready;
  cls_word_t pop_word;

  dfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_word_o  (push_word)
  );

  dfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  dfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_word_i       (pop_word),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .event_res_o      (event_res_o),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .payload_length_o (payload_length_o),
    .wrapped_o        (wrapped_o)
  );

endmodule

`default_nettype wire

// ===== test/dle_frame_receiver_crc16_test.sv =====
// Self-checking testbench for the DLE frame receiver with CRC-16 trailer check.
// Feeds framed, escaped and noisy byte streams and checks every result word
// against an in-bench predictor. Depends on dfr_pkg and dle_frame_receiver_crc16.

module dle_frame_receiver_crc16_test;
  import dfr_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned TailBytes  = 150;
  localparam int unsigned HoldCycles = 60;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] plen;
    logic       wrap;
  } rx_event_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       res_ready = 1'b0;
  logic       rx_ready_o;
  logic       res_valid_o;
  logic [2:0] event_res_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic [7:0] payload_length_o;
  logic       wrapped_o;

  // Raw link bytes waiting to be offered, and result words still to come.
  logic [7:0] pending_bytes[$];
  logic [7:0] frame_body[$];
  rx_event_t  expected_events[$];

  // Predicted deframer state.
  logic        dle_armed = 1'b0;
  int unsigned stored_cnt = 0;
  logic [15:0] frame_crc = 16'h0000;
  logic [7:0]  lag_old = 8'h00;
  logic [7:0]  lag_new = 8'h00;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned good_frames = 0;
  int unsigned rejected_frames = 0;
  int unsigned wrap_events = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  dle_frame_receiver_crc16 dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready),
    .event_res_o      (event_res_o),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .payload_length_o (payload_length_o),
    .wrapped_o        (wrapped_o)
  );

  // XMODEM CRC, one bit at a time, MSB of the byte first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  function automatic logic is_control(input logic [7:0] b);
    return (b == ChSoh) || (b == ChEot) || (b == ChDle);
  endfunction

  // Random byte with a strong lean toward the three control characters.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: b = ChSoh;
        1: b = ChEot;
        default: b = ChDle;
      endcase
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // Works out the result word for one accepted link byte.
  task automatic predict_byte(input logic [7:0] b);
    rx_event_t r;
    logic      store;
    r     = '0;
    store = 1'b0;
    if (stored_cnt >= CountLimit) begin
      stored_cnt = 0;
      frame_crc  = 16'h0000;
      lag_old    = 8'h00;
      lag_new    = 8'h00;
      r.wrap     = 1'b1;
    end
    if (dle_armed) begin
      store = 1'b1;
    end else if (b == ChSoh) begin
      stored_cnt = 0;
      frame_crc  = 16'h0000;
      lag_old    = 8'h00;
      lag_new    = 8'h00;
      r.ev       = EvStart;
    end else if (b == ChEot) begin
      if (stored_cnt > 2 && {lag_new, lag_old} == frame_crc) begin
        r.ev   = EvGood;
        r.plen = 8'(stored_cnt - 2);
      end else begin
        r.ev = EvReject;
      end
    end else if (b == ChDle) begin
      dle_armed = 1'b1;
    end else begin
      store = 1'b1;
    end
    if (store) begin
      dle_armed = 1'b0;
      // The CRC lags two bytes so the trailer itself is never absorbed.
      if (stored_cnt >= 2) begin
        frame_crc = crc16_step(frame_crc, lag_old);
      end
      lag_old    = lag_new;
      lag_new    = b;
      r.ev       = EvStored;
      r.data     = b;
      r.idx      = 8'(stored_cnt);
      stored_cnt = stored_cnt + 1;
    end
    expected_events.push_back(r);
  endtask

  task automatic queue_escaped(input logic [7:0] b);
    if (is_control(b)) begin
      pending_bytes.push_back(ChDle);
    end
    pending_bytes.push_back(b);
  endtask

  task automatic fill_body(input int unsigned n);
    frame_body.delete();
    repeat (n) frame_body.push_back(pick_byte());
  endtask

  // SOH, escaped body, escaped CRC low byte then high byte, EOT.
  task automatic queue_frame(input logic [15:0] crc_flip);
    logic [15:0] crc;
    crc = 16'h0000;
    pending_bytes.push_back(ChSoh);
    foreach (frame_body[i]) begin
      crc = crc16_step(crc, frame_body[i]);
      queue_escaped(frame_body[i]);
    end
    crc = crc ^ crc_flip;
    queue_escaped(crc[7:0]);
    queue_escaped(crc[15:8]);
    pending_bytes.push_back(ChEot);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Sender: offers pending bytes, with random idle bursts until the tail.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'h00;
      gap_left <= 0;
    end else begin
      if (rx_valid && rx_ready_o) begin
        predict_byte(rx_byte);
      end
      if (!rx_valid || rx_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          rx_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          rx_valid <= 1'b0;
        end else if (pending_bytes.size() > TailBytes && $urandom_range(0, 19) == 0) begin
          gap_left <= $urandom_range(0, 10);
          rx_valid <= 1'b0;
        end else begin
          rx_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done  <= 1'b1;
      stall_left <= HoldCycles;
      res_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= (stall_left == 1);
    end else if (pending_bytes.size() > TailBytes && $urandom_range(0, 19) == 0) begin
      stall_left <= $urandom_range(0, 10);
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Monitor: every accepted result word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    rx_event_t e;
    if (rst_ni && res_valid_o && res_ready) begin
      results_seen <= results_seen + 1;
      if (expected_events.size() == 0) begin
        $error("result word with nothing expected: event %0d", event_res_o);
        errors++;
      end else begin
        e = expected_events.pop_front();
        check_field("event_res", e.ev, event_res_o);
        check_field("data_byte", e.data, data_byte_o);
        check_field("byte_index", e.idx, byte_index_o);
        check_field("payload_length", e.plen, payload_length_o);
        check_field("wrapped", e.wrap, wrapped_o);
        if (e.ev == EvGood) good_frames++;
        if (e.ev == EvReject) rejected_frames++;
        if (e.wrap) wrap_events++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** dle_frame_receiver_crc16: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned choice;
    logic        long_done;
    long_done = 1'b0;

    // Good frame with extreme bytes and every control character escaped.
    frame_body = '{8'h00, 8'hFF, ChSoh, ChEot, ChDle};
    queue_frame(16'h0000);
    // Too short, EOT again after the end, lone DLE, then a stray byte.
    pending_bytes.push_back(ChSoh);
    pending_bytes.push_back(8'h55);
    pending_bytes.push_back(ChEot);
    pending_bytes.push_back(ChEot);
    pending_bytes.push_back(ChDle);
    pending_bytes.push_back(8'hAA);
    // Only the CRC bytes, then a bad CRC.
    frame_body.delete();
    queue_frame(16'h0000);
    frame_body = '{8'h12};
    queue_frame(16'h0001);

    while (pending_bytes.size() < 1700) begin
      if (!long_done && pending_bytes.size() > 600) begin
        // Longest good frame, one more byte to wrap on SOH, then a frame
        // whose count wraps exactly at EOT.
        long_done = 1'b1;
        fill_body(CountLimit - 3);
        queue_frame(16'h0000);
        pending_bytes.push_back(8'h33);
        fill_body(CountLimit - 2);
        queue_frame(16'h0000);
      end
      choice = $urandom_range(0, 99);
      if (choice < 65) begin
        fill_body($urandom_range(1, 16));
        queue_frame(16'h0000);
      end else if (choice < 77) begin
        fill_body($urandom_range(0, 16));
        queue_frame(16'h0001 << $urandom_range(0, 15));
      end else if (choice < 90) begin
        repeat ($urandom_range(1, 6)) pending_bytes.push_back(pick_byte());
      end else begin
        pending_bytes.push_back(ChSoh);
        repeat ($urandom_range(0, 3)) queue_escaped(pick_byte());
        if ($urandom_range(0, 1) == 1) begin
          pending_bytes.push_back(ChEot);
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || rx_valid) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d result words: %0d good frames, %0d rejected, %0d count wraps,",
             results_seen, good_frames, rejected_frames, wrap_events);
    $display("with escaped control bytes, corrupted CRCs, noise and a long output stall.");
    if (errors == 0 && expected_events.size() == 0) begin
      $display("** dle_frame_receiver_crc16: PASSED **");
    end else begin
      $display("** dle_frame_receiver_crc16: FAILED **");
    end
    $finish;
  end

endmodule
